/* hdl/lmdd_pkg.sv */
// Package for the lock manager with wait-for deadlock detection.
// Holds sizes, beat structs, status and request codes, and the sequencer states.
// No dependencies.
package lmdd_pkg;

    localparam int LOCK_COUNT = 16;
    localparam int NUM_PROCS  = 16;
    localparam int PID_W      = 4;
    localparam int LOCK_W     = 4;
    localparam int STATUS_W   = 3;
    localparam int CNT_W      = $clog2(NUM_PROCS + 1);
    localparam int SLOT_AW    = LOCK_W + PID_W;
    localparam int SLOT_DEPTH = 2 ** SLOT_AW;

    localparam logic [PID_W:0]  PID_LIMIT  = (PID_W + 1)'(NUM_PROCS);
    localparam logic [LOCK_W:0] LOCK_LIMIT = (LOCK_W + 1)'(LOCK_COUNT);
    localparam logic [CNT_W-1:0] QUEUE_FULL = CNT_W'(NUM_PROCS);
    localparam logic [PID_W-1:0] LAST_SLOT  = PID_W'(NUM_PROCS - 1);

    localparam logic REQ_ACQUIRE = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_GRANTED   = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_QUEUED    = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_OWNER = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_RELEASED  = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_HANDED    = 3'd4;

    typedef struct packed {
        logic              req_type;
        logic [PID_W-1:0]  requester_pid;
        logic [LOCK_W-1:0] lock_id;
    } lmdd_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PID_W-1:0]    new_owner_pid;
        logic                deadlock_found;
    } lmdd_rsp_t;

    typedef struct packed {
        logic             start;
        logic [PID_W-1:0] requester;
        logic [PID_W-1:0] origin;
    } lmdd_walk_ctl_t;

    typedef struct packed {
        logic done;
        logic deadlock;
    } lmdd_walk_res_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_HANDOFF,
        S_WALK,
        S_EMIT
    } lmdd_state_t;

endpackage

/* hdl/lmdd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Used for the per-lock waiter FIFOs. No dependencies.
module lmdd_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 4
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/lmdd_walker.sv */
// Wait-for chain walker: one process visited per cycle through a single step unit.
// Depends on lmdd_pkg; the tables it reads live in the top level.
module lmdd_walker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lmdd_pkg::lmdd_walk_ctl_t      ctl,
    output logic [lmdd_pkg::PID_W-1:0]    proc_addr,
    input  logic                          proc_waiting,
    input  logic [lmdd_pkg::LOCK_W-1:0]   proc_lock,
    output logic [lmdd_pkg::LOCK_W-1:0]   lock_addr,
    input  logic [lmdd_pkg::PID_W-1:0]    lock_owner,
    output lmdd_pkg::lmdd_walk_res_t      res
);

    import lmdd_pkg::*;

    logic                 busy_reg, busy_next;
    logic [PID_W-1:0]     cur_reg, cur_next;
    logic [NUM_PROCS-1:0] seen_reg, seen_next;
    logic [CNT_W-1:0]     steps_reg, steps_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        seen_reg  <= seen_next;
        steps_reg <= steps_next;
    end

    assign proc_addr = cur_reg;
    assign lock_addr = proc_lock;

    always_comb
    begin
        busy_next    = busy_reg;
        cur_next     = cur_reg;
        seen_next    = seen_reg;
        steps_next   = steps_reg;
        res.done     = 1'b0;
        res.deadlock = 1'b0;

        if (ctl.start)
        begin
            busy_next  = 1'b1;
            cur_next   = ctl.origin;
            seen_next  = '0;
            seen_next[ctl.requester] = 1'b1;
            steps_next = '0;
        end
        else if (busy_reg)
        begin
            if (({1'b0, cur_reg} >= PID_LIMIT) || !proc_waiting)
            begin
                res.done  = 1'b1;
                busy_next = 1'b0;
            end
            else if (seen_reg[cur_reg])
            begin
                res.done     = 1'b1;
                res.deadlock = 1'b1;
                busy_next    = 1'b0;
            end
            else if ({1'b0, proc_lock} >= LOCK_LIMIT)
            begin
                res.done  = 1'b1;
                busy_next = 1'b0;
            end
            else
            begin
                seen_next[cur_reg] = 1'b1;
                cur_next           = lock_owner;
                steps_next         = steps_reg + 1'b1;
                // step bound reached without a verdict
                if (steps_reg == QUEUE_FULL)
                begin
                    res.done  = 1'b1;
                    busy_next = 1'b0;
                end
            end
        end
    end

endmodule

/* hdl/lock_manager_deadlock_detect.sv */
// FIFO lock table for LOCK_COUNT locks and NUM_PROCS processes with wait-for cycle
// detection. Requests are taken one at a time. A grant, an error or a release that
// frees the lock passes through accept, decode and the response register; a handoff
// adds a read of the waiter RAM. A queued acquire that enters a waiter FIFO adds the
// wait-for walk, which visits one process per cycle through a single step unit. The
// next request is taken while a response still waits on rsp_ready. No clearing pass
// follows reset. Depends on lmdd_pkg, lmdd_ram and lmdd_walker.
module lock_manager_deadlock_detect (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  lmdd_pkg::lmdd_req_t req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output lmdd_pkg::lmdd_rsp_t rsp
);

    import lmdd_pkg::*;

    lmdd_state_t state_reg, state_next;
    lmdd_req_t   req_reg, req_next;
    lmdd_rsp_t   res_reg, res_next;
    lmdd_rsp_t   rsp_reg, rsp_next;
    logic        rsp_valid_reg, rsp_valid_next;

    logic              lock_busy_reg   [LOCK_COUNT];
    logic              lock_busy_next  [LOCK_COUNT];
    logic [PID_W-1:0]  lock_owner_reg  [LOCK_COUNT];
    logic [PID_W-1:0]  lock_owner_next [LOCK_COUNT];
    logic [PID_W-1:0]  queue_head_reg  [LOCK_COUNT];
    logic [PID_W-1:0]  queue_head_next [LOCK_COUNT];
    logic [CNT_W-1:0]  queue_count_reg [LOCK_COUNT];
    logic [CNT_W-1:0]  queue_count_next[LOCK_COUNT];
    logic              proc_waiting_reg [NUM_PROCS];
    logic              proc_waiting_next[NUM_PROCS];
    logic [LOCK_W-1:0] proc_wait_lock_reg [NUM_PROCS];
    logic              wait_lock_wr;

    logic [LOCK_W-1:0] lk;
    logic [PID_W-1:0]  pid;
    logic [LOCK_W-1:0] owner_addr;
    logic [PID_W-1:0]  owner_rd;
    logic [PID_W-1:0]  head;
    logic [CNT_W-1:0]  count;
    logic [CNT_W:0]    tail_sum;
    logic [CNT_W:0]    tail_wrap;
    logic [PID_W-1:0]  tail;
    logic              range_bad;
    logic [PID_W-1:0]  woken;

    logic                 slot_wr_en;
    logic                 slot_rd_en;
    logic [SLOT_AW-1:0]   slot_wr_addr;
    logic [SLOT_AW-1:0]   slot_rd_addr;
    logic [PID_W-1:0]     slot_rd_data;

    lmdd_walk_ctl_t    walk_ctl;
    lmdd_walk_res_t    walk_res;
    logic [PID_W-1:0]  walk_proc_addr;
    logic [LOCK_W-1:0] walk_lock_addr;

    lmdd_ram #(
        .DEPTH (SLOT_DEPTH),
        .WIDTH (PID_W)
    ) u_slots (
        .clk     (clk),
        .wr_en   (slot_wr_en),
        .wr_addr (slot_wr_addr),
        .wr_data (pid),
        .rd_en   (slot_rd_en),
        .rd_addr (slot_rd_addr),
        .rd_data (slot_rd_data)
    );

    lmdd_walker u_walker (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (walk_ctl),
        .proc_addr    (walk_proc_addr),
        .proc_waiting (proc_waiting_reg[walk_proc_addr]),
        .proc_lock    (proc_wait_lock_reg[walk_proc_addr]),
        .lock_addr    (walk_lock_addr),
        .lock_owner   (owner_rd),
        .res          (walk_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < LOCK_COUNT; i++)
            begin
                lock_busy_reg[i]   <= 1'b0;
                lock_owner_reg[i]  <= '0;
                queue_head_reg[i]  <= '0;
                queue_count_reg[i] <= '0;
            end
            for (int i = 0; i < NUM_PROCS; i++)
            begin
                proc_waiting_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            rsp_valid_reg    <= rsp_valid_next;
            lock_busy_reg    <= lock_busy_next;
            lock_owner_reg   <= lock_owner_next;
            queue_head_reg   <= queue_head_next;
            queue_count_reg  <= queue_count_next;
            proc_waiting_reg <= proc_waiting_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        res_reg <= res_next;
        rsp_reg <= rsp_next;
        if (wait_lock_wr)
        begin
            proc_wait_lock_reg[pid] <= lk;
        end
    end

    assign lk         = req_reg.lock_id;
    assign pid        = req_reg.requester_pid;
    assign owner_addr = (state_reg == S_WALK) ? walk_lock_addr : lk;
    assign owner_rd   = lock_owner_reg[owner_addr];
    assign head       = queue_head_reg[lk];
    assign count      = queue_count_reg[lk];
    assign range_bad  = ({1'b0, lk} >= LOCK_LIMIT) || ({1'b0, pid} >= PID_LIMIT);

    // tail = (head + count) mod NUM_PROCS; the sum stays below twice NUM_PROCS
    assign tail_sum  = (CNT_W + 1)'(head) + (CNT_W + 1)'(count);
    assign tail_wrap = tail_sum - (CNT_W + 1)'(NUM_PROCS);
    assign tail      = (tail_sum >= (CNT_W + 1)'(NUM_PROCS)) ? tail_wrap[PID_W-1:0]
                                                             : tail_sum[PID_W-1:0];

    assign slot_wr_addr = {lk, tail};
    assign slot_rd_addr = {lk, head};
    assign woken        = ({1'b0, slot_rd_data} >= PID_LIMIT) ? '0 : slot_rd_data;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next        = state_reg;
        req_next          = req_reg;
        res_next          = res_reg;
        rsp_next          = rsp_reg;
        rsp_valid_next    = rsp_valid_reg && !rsp_ready;
        lock_busy_next    = lock_busy_reg;
        lock_owner_next   = lock_owner_reg;
        queue_head_next   = queue_head_reg;
        queue_count_next  = queue_count_reg;
        proc_waiting_next = proc_waiting_reg;
        wait_lock_wr      = 1'b0;
        slot_wr_en        = 1'b0;
        slot_rd_en        = 1'b0;
        walk_ctl.start     = 1'b0;
        walk_ctl.requester = pid;
        walk_ctl.origin    = owner_rd;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                state_next = S_EMIT;
                res_next.status         = STAT_NOT_OWNER;
                res_next.new_owner_pid  = '0;
                res_next.deadlock_found = 1'b0;
                if (range_bad)
                begin
                    res_next.status = STAT_NOT_OWNER;
                end
                else if (req_reg.req_type == REQ_ACQUIRE)
                begin
                    if (!lock_busy_reg[lk])
                    begin
                        lock_busy_next[lk]     = 1'b1;
                        lock_owner_next[lk]    = pid;
                        res_next.status        = STAT_GRANTED;
                        res_next.new_owner_pid = pid;
                    end
                    else if (count >= QUEUE_FULL)
                    begin
                        res_next.status        = STAT_QUEUED;
                        res_next.new_owner_pid = owner_rd;
                    end
                    else
                    begin
                        proc_waiting_next[pid] = 1'b1;
                        wait_lock_wr           = 1'b1;
                        slot_wr_en             = 1'b1;
                        queue_count_next[lk]   = count + 1'b1;
                        res_next.status        = STAT_QUEUED;
                        res_next.new_owner_pid = owner_rd;
                        walk_ctl.start         = 1'b1;
                        state_next             = S_WALK;
                    end
                end
                else if (!lock_busy_reg[lk])
                begin
                    res_next.status = STAT_NOT_OWNER;
                end
                else if (owner_rd != pid)
                begin
                    res_next.status        = STAT_NOT_OWNER;
                    res_next.new_owner_pid = owner_rd;
                end
                else if (count == '0)
                begin
                    lock_busy_next[lk]     = 1'b0;
                    lock_owner_next[lk]    = '0;
                    proc_waiting_next[pid] = 1'b0;
                    res_next.status        = STAT_RELEASED;
                end
                else
                begin
                    // head waiter comes back from the RAM next cycle
                    slot_rd_en = 1'b1;
                    state_next = S_HANDOFF;
                end
            end

            S_HANDOFF:
            begin
                queue_head_next[lk]      = (head == LAST_SLOT) ? '0 : head + 1'b1;
                queue_count_next[lk]     = count - 1'b1;
                lock_owner_next[lk]      = woken;
                proc_waiting_next[woken] = 1'b0;
                res_next.status          = STAT_HANDED;
                res_next.new_owner_pid   = woken;
                res_next.deadlock_found  = 1'b0;
                state_next               = S_EMIT;
            end

            S_WALK:
            begin
                if (walk_res.done)
                begin
                    res_next.deadlock_found = walk_res.deadlock;
                    state_next              = S_EMIT;
                end
            end

            S_EMIT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // the walker only reports while the sequencer waits on it
    assert property (@(posedge clk) disable iff (!rst_n)
        walk_res.done |-> (state_reg == S_WALK))
        else $error("walk finished outside the walk state");

    // a deadlock flag only ever rides on a queued acquire
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.deadlock_found) |-> (rsp_reg.status == STAT_QUEUED))
        else $error("deadlock flag on a non-queued response");

    // a waiter FIFO never holds more than QUEUE_FULL entries
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECODE) |-> (count <= QUEUE_FULL))
        else $error("queue count above capacity");

    // a handoff is only reached from a release by the owner with waiters queued
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HANDOFF) |-> ($past(state_reg) == S_DECODE
            && req_reg.req_type == REQ_RELEASE && count != '0))
        else $error("handoff without queued waiters");

endmodule

/* verif/lmdd_check.sv */
`timescale 1ns / 1ps
// Checker for lock_manager_deadlock_detect: watches both channels, keeps its own lock table
// and wait-for walk, and checks every response beat in order. Depends on lmdd_pkg.
module lmdd_check (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_ready,
    input  lmdd_pkg::lmdd_req_t req,
    input  logic                rsp_valid,
    input  logic                rsp_ready,
    input  lmdd_pkg::lmdd_rsp_t rsp,
    input  logic                closing,
    output int                  errors,
    output int                  pending,
    output int                  checked,
    output int                  handoffs,
    output int                  deadlocks,
    output logic [lmdd_pkg::LOCK_COUNT-1:0]                      busy_map,
    output logic [lmdd_pkg::LOCK_COUNT-1:0][lmdd_pkg::PID_W-1:0] owner_map
);

    import lmdd_pkg::*;

    typedef struct packed {
        lmdd_req_t cause;
        lmdd_rsp_t want;
    } owed_rsp_t;

    // lock table as the block should hold it
    logic [LOCK_COUNT-1:0]            held;
    logic [LOCK_COUNT-1:0][PID_W-1:0] holder;
    logic [PID_W-1:0]                 slot [LOCK_COUNT][NUM_PROCS];
    logic [PID_W-1:0]                 qhead [LOCK_COUNT];
    logic [CNT_W-1:0]                 qcount [LOCK_COUNT];
    logic [NUM_PROCS-1:0]             waiting;
    logic [LOCK_W-1:0]                waits_on [NUM_PROCS];

    owed_rsp_t owed[$];
    logic      closed;

    task automatic flag(input string what);
        errors++;
        if (errors <= 100)
            $display("%0t ns lmdd_check: %s", $time, what);
    endtask

    // follow owner -> awaited lock -> owner; a revisit means a cycle
    function automatic logic closes_cycle(logic [PID_W-1:0] requester,
                                          logic [PID_W-1:0] first);
        logic [NUM_PROCS-1:0] seen;
        logic [PID_W-1:0]     cur;
        seen = '0;
        seen[requester] = 1'b1;
        cur = first;
        for (int step = 0; step <= NUM_PROCS; step++)
        begin
            if (!waiting[cur])
                return 1'b0;
            if (seen[cur])
                return 1'b1;
            seen[cur] = 1'b1;
            cur = holder[waits_on[cur]];
        end
        return 1'b0;
    endfunction

    // applies one request to the table and returns the response it owes
    // (lock and pid fields cannot exceed the table at these widths)
    function automatic lmdd_rsp_t apply_request(lmdd_req_t r);
        lmdd_rsp_t         o;
        logic [PID_W-1:0]  p;
        logic [PID_W-1:0]  nxt;
        logic [PID_W-1:0]  tail;
        logic [LOCK_W-1:0] k;
        p = r.requester_pid;
        k = r.lock_id;
        o.status = STAT_NOT_OWNER;
        o.new_owner_pid = '0;
        o.deadlock_found = 1'b0;
        if (r.req_type == REQ_ACQUIRE)
        begin
            if (!held[k])
            begin
                held[k] = 1'b1;
                holder[k] = p;
                o.status = STAT_GRANTED;
                o.new_owner_pid = p;
            end
            else
            begin
                o.status = STAT_QUEUED;
                o.new_owner_pid = holder[k];
                // full queue drops the request silently
                if (qcount[k] < QUEUE_FULL)
                begin
                    waiting[p] = 1'b1;
                    waits_on[p] = k;
                    tail = qhead[k] + qcount[k][PID_W-1:0];
                    slot[k][tail] = p;
                    qcount[k] = qcount[k] + 1'b1;
                    o.deadlock_found = closes_cycle(p, holder[k]);
                end
            end
        end
        else if (held[k])
        begin
            if (holder[k] != p)
            begin
                o.new_owner_pid = holder[k];
            end
            else if (qcount[k] == '0)
            begin
                held[k] = 1'b0;
                holder[k] = '0;
                waiting[p] = 1'b0;
                o.status = STAT_RELEASED;
            end
            else
            begin
                nxt = slot[k][qhead[k]];
                qhead[k] = qhead[k] + 1'b1;
                qcount[k] = qcount[k] - 1'b1;
                holder[k] = nxt;
                waiting[nxt] = 1'b0;
                o.status = STAT_HANDED;
                o.new_owner_pid = nxt;
            end
        end
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        owed_rsp_t e;
        owed_rsp_t fresh;
        if (!rst_n)
        begin
            held = '0;
            holder = '0;
            waiting = '0;
            foreach (qhead[i])
            begin
                qhead[i] = '0;
                qcount[i] = '0;
            end
            owed.delete();
            closed = 1'b0;
            errors = 0;
            pending = 0;
            checked = 0;
            handoffs = 0;
            deadlocks = 0;
            busy_map <= '0;
            owner_map <= '0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (owed.size() == 0)
                begin
                    flag($sformatf("response beat with nothing owed: status %0d owner %0d dl %0b",
                                   rsp.status, rsp.new_owner_pid, rsp.deadlock_found));
                end
                else
                begin
                    e = owed.pop_front();
                    checked++;
                    if (e.want.status == STAT_HANDED)
                        handoffs++;
                    if (e.want.deadlock_found)
                        deadlocks++;
                    if (rsp.status !== e.want.status)
                        flag($sformatf("status %0d, want %0d (type %0b pid %0d lock %0d)",
                                       rsp.status, e.want.status, e.cause.req_type,
                                       e.cause.requester_pid, e.cause.lock_id));
                    if (rsp.new_owner_pid !== e.want.new_owner_pid)
                        flag($sformatf("owner %0d, want %0d (type %0b pid %0d lock %0d)",
                                       rsp.new_owner_pid, e.want.new_owner_pid,
                                       e.cause.req_type, e.cause.requester_pid,
                                       e.cause.lock_id));
                    if (rsp.deadlock_found !== e.want.deadlock_found)
                        flag($sformatf("deadlock %0b, want %0b (type %0b pid %0d lock %0d)",
                                       rsp.deadlock_found, e.want.deadlock_found,
                                       e.cause.req_type, e.cause.requester_pid,
                                       e.cause.lock_id));
                end
            end
            if (req_valid && req_ready)
            begin
                fresh.cause = req;
                fresh.want = apply_request(req);
                owed.push_back(fresh);
            end
            if (closing && !closed)
            begin
                closed = 1'b1;
                if (owed.size() != 0)
                    flag($sformatf("%0d responses never arrived", owed.size()));
            end
            pending = owed.size();
            busy_map <= held;
            owner_map <= holder;
        end
    end

endmodule

/* verif/lock_manager_deadlock_detect_test.sv */
`timescale 1ns / 1ps
// Top of the lock manager testbench: clock, reset, request and response traffic, verdict.
// Depends on lmdd_pkg, lock_manager_deadlock_detect and lmdd_check.
module lock_manager_deadlock_detect_test;
    import lmdd_pkg::*;

    localparam int TOTAL_ITEMS = 1450;
    localparam int CALM_ITEMS  = 150;
    localparam int STALL_AT    = 600;
    localparam int STALL_LEN   = 400;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    lmdd_req_t req = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    lmdd_rsp_t rsp;
    logic      closing = 1'b0;

    int errors;
    int pending;
    int checked;
    int handoffs;
    int deadlocks;
    logic [LOCK_COUNT-1:0]            busy_map;
    logic [LOCK_COUNT-1:0][PID_W-1:0] owner_map;

    int unsigned accepted = 0;
    logic        calm = 1'b0;
    int unsigned lock_base = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    lock_manager_deadlock_detect u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    lmdd_check u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .closing   (closing),
        .errors    (errors),
        .pending   (pending),
        .checked   (checked),
        .handoffs  (handoffs),
        .deadlocks (deadlocks),
        .busy_map  (busy_map),
        .owner_map (owner_map)
    );

    function automatic lmdd_req_t make_req(logic kind, int unsigned pid, int unsigned lk);
        lmdd_req_t r;
        r.req_type = kind;
        r.requester_pid = PID_W'(pid);
        r.lock_id = LOCK_W'(lk);
        return r;
    endfunction

    // mostly contention on a few locks among a few pids, releases mostly by the
    // holder so handoffs and wait-for cycles keep happening; the rest is noise
    function automatic lmdd_req_t random_req();
        int unsigned roll;
        int unsigned lk;
        int unsigned pid;
        roll = $urandom_range(0, 99);
        lk = (lock_base + $urandom_range(0, 3)) % LOCK_COUNT;
        pid = ($urandom_range(0, 4) == 0) ? $urandom_range(0, NUM_PROCS - 1)
                                          : $urandom_range(0, 5);
        if (roll < 12)
            return make_req(1'($urandom_range(0, 1)), $urandom_range(0, NUM_PROCS - 1),
                            $urandom_range(0, LOCK_COUNT - 1));
        if (roll < 55)
        begin
            if (busy_map[lk] && roll < 50)
                return make_req(REQ_RELEASE, owner_map[lk], lk);
            return make_req(REQ_RELEASE, pid, lk);
        end
        return make_req(REQ_ACQUIRE, pid, lk);
    endfunction

    // holds the beat until accepted; valid stays up for the caller to decide
    task automatic offer(input lmdd_req_t r);
        req <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        accepted++;
    endtask

    task automatic maybe_gap();
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    initial
    begin : stimulus
        int unsigned waited;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer(make_req(REQ_ACQUIRE, 0, 0));
        offer(make_req(REQ_ACQUIRE, 15, 15));
        offer(make_req(REQ_RELEASE, 0, 15));     // not the owner
        offer(make_req(REQ_RELEASE, 3, 5));      // lock is free
        offer(make_req(REQ_ACQUIRE, 15, 15));    // owner queues on itself
        repeat (NUM_PROCS - 1)
            offer(make_req(REQ_ACQUIRE, $urandom_range(0, NUM_PROCS - 1), 15));
        offer(make_req(REQ_ACQUIRE, 7, 15));     // queue full, dropped
        offer(make_req(REQ_RELEASE, 15, 15));    // handoff to head waiter
        offer(make_req(REQ_RELEASE, 0, 0));      // empty queue, lock freed

        while (accepted < TOTAL_ITEMS)
        begin
            if (accepted % 150 == 0)
                lock_base = $urandom_range(0, LOCK_COUNT - 1);
            if (accepted >= TOTAL_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            maybe_gap();
            offer(random_req());
        end
        req_valid <= 1'b0;

        waited = 0;
        while (pending != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (40) @(posedge clk);
        closing <= 1'b1;
        repeat (2) @(posedge clk);

        $display("%0d requests, %0d responses checked; %0d handoffs, %0d wait-for cycles flagged",
                 accepted, checked, handoffs, deadlocks);
        $display("covered full queue, self-wait, bad releases and a %0d-cycle response stall",
                 STALL_LEN);
        if (errors == 0)
            $display("lock_manager_deadlock_detect_test: done, clean");
        else
            $display("lock_manager_deadlock_detect_test: done, errors");
        $finish;
    end

    initial
    begin : receiver
        logic stalled;
        stalled = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (!stalled && accepted >= STALL_AT)
            begin
                // long hold-off so the block backs up into the request side
                stalled = 1'b1;
                rsp_ready <= 1'b0;
                repeat (STALL_LEN) @(posedge clk);
                rsp_ready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
                rsp_ready <= 1'b1;
            end
            else
            begin
                rsp_ready <= 1'b1;
            end
        end
    end

    initial
    begin : watchdog
        #6_000_000;
        $display("lock_manager_deadlock_detect_test: done, errors");
        $finish;
    end

endmodule

/* filelist.f */
hdl/lmdd_pkg.sv
hdl/lmdd_ram.sv
hdl/lmdd_walker.sv
hdl/lock_manager_deadlock_detect.sv
verif/lmdd_check.sv
verif/lock_manager_deadlock_detect_test.sv
